// ===== sv/fprc8_pkg.sv =====
package fprc8_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'hA5;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h5A;
	localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN,
		ST_BODY,
		ST_CRC,
		ST_END,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic len_ld;
		logic body_wr;
		logic crc_wr;
		logic emit_start;
		logic rd_en;
		logic out_ld;
		logic emit_next;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_start;
		logic len_ok;
		logic body_done;
		logic end_ok;
		logic emit_last;
		logic out_free;
	} dp_sts_t;

	// One byte of CRC-8, MSB first; the top bit test stands for the 0x80 mask.
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
							  input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/fprc8_ctrl.sv =====
module fprc8_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fprc8_pkg::dp_sts_t sts,
	output fprc8_pkg::dp_cmd_t cmd
);
	import fprc8_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b0;
		in_acc    = in_valid;
		case (state_q)
			ST_HUNT: begin
				if (in_acc && sts.is_start) begin
					state_nxt = ST_LEN;
				end
			end
			ST_LEN: begin
				if (in_acc) begin
					if (sts.len_ok) begin
						cmd.len_ld = 1'b1;
						state_nxt  = ST_BODY;
					end else begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_BODY: begin
				if (in_acc) begin
					cmd.body_wr = 1'b1;
					if (sts.body_done) begin
						state_nxt = ST_CRC;
					end
				end
			end
			ST_CRC: begin
				if (in_acc) begin
					cmd.crc_wr = 1'b1;
					state_nxt  = ST_END;
				end
			end
			ST_END: begin
				if (in_acc) begin
					if (sts.end_ok) begin
						cmd.emit_start = 1'b1;
						state_nxt      = ST_EMIT_RD;
					end else begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_EMIT_RD: begin
				in_stall  = 1'b1;
				cmd.rd_en = 1'b1;
				state_nxt = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				in_stall = 1'b1;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (sts.emit_last) begin
						state_nxt = ST_HUNT;
					end else begin
						cmd.emit_next = 1'b1;
						state_nxt     = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

endmodule

// ===== sv/fprc8_dp.sv =====
module fprc8_dp #(
	parameter int STORE_DEPTH  = 64,
	parameter int MAX_BODY_LEN = 63
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [fprc8_pkg::BYTE_W-1:0]           rx_byte,
	input  fprc8_pkg::dp_cmd_t                     cmd,
	output fprc8_pkg::dp_sts_t                     sts,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic [fprc8_pkg::BYTE_W-1:0]           opcode,
	output logic [fprc8_pkg::LEN_W-1:0]            payload_len,
	output logic [fprc8_pkg::BYTE_W-1:0]           payload_byte,
	output logic [fprc8_pkg::LEN_W-1:0]            payload_index,
	output logic                                   has_byte,
	output logic                                   last
);
	import fprc8_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = BYTE_W + 1;
	localparam logic [CW-1:0] DEPTH_V   = CW'(STORE_DEPTH);
	localparam logic [CW-1:0] MAX_LEN_V = CW'(MAX_BODY_LEN);

	logic [BYTE_W-1:0] mem [STORE_DEPTH];

	logic [BYTE_W-1:0] frame_len_q;
	logic [BYTE_W-1:0] byte_count_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_rx_q;
	logic [BYTE_W-1:0] opcode_q;
	logic [BYTE_W-1:0] idx_q;
	logic [BYTE_W-1:0] rd_q;
	logic              rd_ok_q;
	logic              out_valid_q;

	logic              wr_ok;
	logic [CW-1:0]     count_nxt;
	logic [BYTE_W-1:0] crc_in;
	logic [BYTE_W-1:0] plen;
	logic [BYTE_W-1:0] rd_idx;
	logic              has_pl;

	assign wr_ok     = {1'b0, byte_count_q} < DEPTH_V;
	assign count_nxt = {1'b0, byte_count_q} + CW'(1);
	// Bytes beyond the store read back as zero, so the CRC sees zero too.
	assign crc_in    = wr_ok ? rx_byte : '0;
	assign plen      = frame_len_q - BYTE_W'(1);
	assign rd_idx    = idx_q + BYTE_W'(1);
	assign has_pl    = plen != '0;

	assign sts.is_start  = rx_byte == START_BYTE;
	assign sts.len_ok    = (rx_byte != '0) && ({1'b0, rx_byte} <= MAX_LEN_V);
	assign sts.body_done = count_nxt >= {1'b0, frame_len_q};
	assign sts.end_ok    = (rx_byte == END_BYTE) && (crc_q == crc_rx_q);
	assign sts.emit_last = !has_pl || (rd_idx == plen);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.body_wr && wr_ok) begin
			mem[byte_count_q[AW-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q    <= mem[rd_idx[AW-1:0]];
			rd_ok_q <= {1'b0, rd_idx} < DEPTH_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q  <= '0;
			byte_count_q <= '0;
		end else if (cmd.len_ld) begin
			frame_len_q  <= rx_byte;
			byte_count_q <= '0;
		end else if (cmd.body_wr) begin
			byte_count_q <= count_nxt[BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.len_ld) begin
			crc_q <= '0;
		end else if (cmd.body_wr) begin
			crc_q <= crc8_update(crc_q, crc_in);
		end
		if (cmd.body_wr && (byte_count_q == '0)) begin
			opcode_q <= rx_byte;
		end
		if (cmd.crc_wr) begin
			crc_rx_q <= ({1'b0, frame_len_q} < DEPTH_V) ? rx_byte : '0;
		end
		if (cmd.emit_start) begin
			idx_q <= '0;
		end else if (cmd.emit_next) begin
			idx_q <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			opcode        <= opcode_q;
			payload_len   <= plen[LEN_W-1:0];
			payload_byte  <= (has_pl && rd_ok_q) ? rd_q : '0;
			payload_index <= has_pl ? idx_q[LEN_W-1:0] : '0;
			has_byte      <= has_pl;
			last          <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/framed_packet_receiver_crc8.sv =====
// Framed packet receiver with CRC-8 check.
// Input channel (in_valid, in_stall, rx_byte): one received byte per transaction.
// The receiver hunts for the start byte 0xA5, takes a length byte of 1..MAX_BODY_LEN,
// then the body (opcode and payload), a CRC byte and the end byte 0x5A.
// Output channel (out_valid, out_stall and the result fields): a good frame is
// delivered as one transaction per payload byte, or one transaction without a
// byte when the payload is empty; last marks the final one. Bad frames vanish.
// Throughput: one input byte per cycle while a frame is being received. After an
// accepted end byte the input stalls for the emit run, in which each result takes
// a store read and then an output load, plus any wait while the output stalls.
// The first result follows the end byte through the store read and output load states.
// An output register separates the two sides, so the final result of a run may
// wait on a stalled output while the next frame's bytes are already taken.
// Reset puts the receiver back to hunting with no result pending. The frame store
// is not cleared; every read that delivers a byte follows a write in the same frame.
module framed_packet_receiver_crc8 #(
	parameter int STORE_DEPTH  = 64,
	parameter int MAX_BODY_LEN = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [fprc8_pkg::BYTE_W-1:0] rx_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fprc8_pkg::BYTE_W-1:0] opcode,
	output logic [fprc8_pkg::LEN_W-1:0]  payload_len,
	output logic [fprc8_pkg::BYTE_W-1:0] payload_byte,
	output logic [fprc8_pkg::LEN_W-1:0]  payload_index,
	output logic                         has_byte,
	output logic                         last
);
	import fprc8_pkg::*;

	// Command and status groups between the sequencer and the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller walks the frame fields and, after a good frame, steps the
	// emit run one stored byte at a time.
	fprc8_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the frame store, the running CRC, the counters and the
	// output register.
	fprc8_dp #(
		.STORE_DEPTH  (STORE_DEPTH),
		.MAX_BODY_LEN (MAX_BODY_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.opcode        (opcode),
		.payload_len   (payload_len),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.has_byte      (has_byte),
		.last          (last)
	);

endmodule

// ===== tb/sv/fprc8_frame_checker.sv =====
module fprc8_frame_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [fprc8_pkg::BYTE_W-1:0] rx_byte,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [fprc8_pkg::BYTE_W-1:0] opcode,
	input  logic [fprc8_pkg::LEN_W-1:0]  payload_len,
	input  logic [fprc8_pkg::BYTE_W-1:0] payload_byte,
	input  logic [fprc8_pkg::LEN_W-1:0]  payload_index,
	input  logic                         has_byte,
	input  logic                         last,
	output int                           mismatch_count,
	output int                           results_waiting,
	output int                           results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import fprc8_pkg::*;

	localparam int MAX_BODY = 63;

	typedef struct packed {
		logic [BYTE_W-1:0] opcode;
		logic [LEN_W-1:0]  payload_len;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  payload_index;
		logic              has_byte;
		logic              last;
	} frame_result_t;

	frame_result_t     result_q[$];
	state_t            rx_phase;
	logic [LEN_W-1:0]  body_len;
	logic [LEN_W-1:0]  body_cnt;
	logic [BYTE_W-1:0] body_mem [0:63];
	int                errs = 0;
	int                seen = 0;

	function automatic logic [BYTE_W-1:0] body_crc(input int n);
		logic [BYTE_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < n; i++) begin
			acc = acc ^ body_mem[i];
			for (int b = 0; b < BYTE_W; b++) begin
				acc = acc[BYTE_W-1] ? ({acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
						    : {acc[BYTE_W-2:0], 1'b0};
			end
		end
		return acc;
	endfunction

	// A frame that passed both checks becomes its run of results.
	task automatic queue_frame_results();
		frame_result_t r;
		int            plen;
		plen = int'(body_len) - 1;
		if (plen == 0) begin
			r = '0;
			r.opcode = body_mem[0];
			r.last = 1'b1;
			result_q.push_back(r);
		end else begin
			for (int i = 0; i < plen; i++) begin
				r.opcode = body_mem[0];
				r.payload_len = LEN_W'(plen);
				r.payload_byte = body_mem[i+1];
				r.payload_index = LEN_W'(i);
				r.has_byte = 1'b1;
				r.last = (i == plen - 1);
				result_q.push_back(r);
			end
		end
	endtask

	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		case (rx_phase)
			ST_LEN: begin
				if (b == 0 || b > MAX_BODY) begin
					rx_phase = ST_HUNT;
				end else begin
					body_len = LEN_W'(b);
					body_cnt = '0;
					rx_phase = ST_BODY;
				end
			end
			ST_BODY: begin
				body_mem[body_cnt] = b;
				body_cnt = body_cnt + 1'b1;
				if (body_cnt >= body_len) begin
					rx_phase = ST_CRC;
				end
			end
			ST_CRC: begin
				body_mem[body_cnt] = b;
				rx_phase = ST_END;
			end
			ST_END: begin
				if (b == END_BYTE && body_crc(body_len) == body_mem[body_len]) begin
					queue_frame_results();
				end
				rx_phase = ST_HUNT;
			end
			default: begin
				rx_phase = (b == START_BYTE) ? ST_LEN : ST_HUNT;
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
					    input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			errs++;
		end
	endfunction

	task automatic check_result();
		frame_result_t want;
		if (result_q.size() == 0) begin
			$error("result with no frame pending: opcode 0x%02h index %0d", opcode,
			       payload_index);
			errs++;
		end else begin
			want = result_q.pop_front();
			check_field("opcode", want.opcode, opcode);
			check_field("payload_len", BYTE_W'(want.payload_len), BYTE_W'(payload_len));
			check_field("payload_byte", want.payload_byte, payload_byte);
			check_field("payload_index", BYTE_W'(want.payload_index),
				    BYTE_W'(payload_index));
			check_field("has_byte", BYTE_W'(want.has_byte), BYTE_W'(has_byte));
			check_field("last", BYTE_W'(want.last), BYTE_W'(last));
		end
		seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase = ST_HUNT;
			body_len = '0;
			body_cnt = '0;
			result_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (in_valid && !in_stall) begin
				absorb_byte(rx_byte);
			end
		end
		mismatch_count <= errs;
		results_waiting <= result_q.size();
		results_checked <= seen;
	end

endmodule

// ===== tb/sv/framed_packet_receiver_crc8_tb.sv =====
module framed_packet_receiver_crc8_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fprc8_pkg::*;

	// Frame bytes to send over the whole run. Noise bytes that the receiver
	// only hunts through are not counted.
	localparam int FRAME_ITEMS    = 160;
	// Length of the single long output hold-off that backs the receiver up.
	localparam int HOLD_CYCLES    = 300;
	// Cycles without any transaction on either side before the run is abandoned.
	// The longest legal quiet stretch is the hold-off above.
	localparam int WATCHDOG_LIMIT = 3000;
	// Cycles to keep watching after the last expected result, to catch strays.
	localparam int TAIL_CYCLES    = 40;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_END
	} frame_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] opcode;
	logic [LEN_W-1:0]  payload_len;
	logic [BYTE_W-1:0] payload_byte;
	logic [LEN_W-1:0]  payload_index;
	logic              has_byte;
	logic              last;

	int mismatch_count;
	int results_waiting;
	int results_checked;

	// Shared pacing controls. When idle_on is clear, neither side inserts gaps,
	// which gives back-to-back stretches. hold_req asks the output side for one
	// long hold-off, starting after its next transaction.
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	int frame_items = 0;
	int frames_intact = 0;
	int frames_damaged = 0;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	framed_packet_receiver_crc8 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.opcode        (opcode),
		.payload_len   (payload_len),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.has_byte      (has_byte),
		.last          (last)
	);

	// The checker follows every transaction on both channels, predicts the
	// result runs and compares them. It reports back how many mismatches it
	// saw and how many results are still owed.
	fprc8_frame_checker i_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.opcode          (opcode),
		.payload_len     (payload_len),
		.payload_byte    (payload_byte),
		.payload_index   (payload_index),
		.has_byte        (has_byte),
		.last            (last),
		.mismatch_count  (mismatch_count),
		.results_waiting (results_waiting),
		.results_checked (results_checked)
	);

	// CRC-8 that a well-behaved transmitter would append to the body.
	function automatic logic [BYTE_W-1:0] frame_crc(input logic [BYTE_W-1:0] body [$]);
		logic [BYTE_W-1:0] acc;
		acc = '0;
		foreach (body[i]) begin
			acc = acc ^ body[i];
			repeat (BYTE_W) begin
				acc = acc[BYTE_W-1] ? ({acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
						    : {acc[BYTE_W-2:0], 1'b0};
			end
		end
		return acc;
	endfunction

	// Offers one byte and returns at the clock edge where the transaction is
	// taken. A random gap may come first. Valid stays high between back-to-back
	// bytes, so it is never lowered and raised within one time step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Sends a whole frame: start byte, length, opcode plus random payload, CRC
	// and end byte. A damaged CRC has one bit flipped; a damaged end byte is
	// anything other than the real end byte.
	task automatic send_frame(input int body_n, input frame_kind_t kind,
				  input logic [BYTE_W-1:0] op);
		logic [BYTE_W-1:0] body [$];
		logic [BYTE_W-1:0] crc;
		body.push_back(op);
		for (int i = 1; i < body_n; i++) begin
			body.push_back(BYTE_W'($urandom_range(0, 255)));
		end
		crc = frame_crc(body);
		if (kind == FRAME_BAD_CRC) begin
			crc = crc ^ (8'h01 << $urandom_range(0, 7));
		end
		send_byte(START_BYTE);
		send_byte(BYTE_W'(body_n));
		foreach (body[i]) begin
			send_byte(body[i]);
		end
		send_byte(crc);
		if (kind == FRAME_BAD_END) begin
			send_byte(END_BYTE ^ BYTE_W'($urandom_range(1, 255)));
		end else begin
			send_byte(END_BYTE);
		end
		frame_items += body_n + 4;
		if (kind == FRAME_GOOD) begin
			frames_intact++;
		end else begin
			frames_damaged++;
		end
	endtask

	// Mostly short bodies, with the occasional long one up to the maximum.
	function automatic int pick_body_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
	endfunction

	// Output side. Before each result it may hold off for a random pause, then it
	// keeps stall low until a result is taken. Once, on request, it holds off
	// for a long stretch so that the output register and the emit run back up
	// into the input channel.
	initial begin
		int pause;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pause = idle_on ? $urandom_range(0, 3) : 0;
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: a run that goes quiet on both channels for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int pick;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Noise in the hunting state first.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Zero length and the first length past the maximum both drop back
		// to hunting.
		send_byte(START_BYTE);
		send_byte(8'h00);
		send_byte(START_BYTE);
		send_byte(8'd64);
		// A start byte where the length belongs is a bad length, not a new
		// start; a real frame follows right after it.
		send_byte(START_BYTE);
		send_byte(START_BYTE);
		// Empty payload with the highest opcode, then a one-byte payload
		// with the lowest.
		send_frame(1, FRAME_GOOD, 8'hFF);
		send_frame(2, FRAME_GOOD, 8'h00);
		// Damaged frames must vanish without a result.
		send_frame(1, FRAME_BAD_CRC, BYTE_W'($urandom_range(0, 255)));
		send_frame(2, FRAME_BAD_END, BYTE_W'($urandom_range(0, 255)));

		// The longest body, once, so payload_len and payload_index reach
		// their top values.
		send_frame(63, FRAME_GOOD, BYTE_W'($urandom_range(0, 255)));

		// Pressure: the output side holds off while three frames go in
		// back to back, so the receiver fills up and stalls its input.
		idle_on = 1'b0;
		hold_req = 1'b1;
		repeat (3) begin
			send_frame($urandom_range(3, 8), FRAME_GOOD, BYTE_W'($urandom_range(0, 255)));
		end

		// Random part: mostly intact frames with random content, the rest
		// damaged frames, bad lengths and noise. Pacing changes per frame.
		while (frame_items < FRAME_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_frame(pick_body_len(), FRAME_GOOD, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				send_frame(pick_body_len(), FRAME_BAD_CRC, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 83) begin
				send_frame(pick_body_len(), FRAME_BAD_END, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 91) begin
				send_byte(START_BYTE);
				send_byte($urandom_range(0, 1) ? 8'h00 : BYTE_W'($urandom_range(64, 255)));
				frame_items += 2;
				frames_damaged++;
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every expected result, then watch a little longer
		// for anything the receiver should not have produced.
		do @(posedge clk); while (results_waiting != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d intact and %0d damaged or malformed frames, longest body included,",
			 frames_intact, frames_damaged);
		$display("with one long output hold-off; %0d results were checked.", results_checked);
		if (results_waiting != 0) begin
			$error("%0d expected results never arrived", results_waiting);
		end
		if (mismatch_count == 0 && results_waiting == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
